// ----- rtl/core/shp_pkg.sv -----
package shp_pkg;

    localparam int unsigned CntW   = 16;
    localparam int unsigned AngW   = 8;
    localparam int unsigned PhaseW = 3;
    localparam int unsigned CoilW  = 4;
    localparam int unsigned AddrW  = 5;
    localparam int unsigned DataW  = 32;

    localparam logic [CntW-1:0] CntMax = '1;

    localparam logic [CntW-1:0] RstStepInterval = 16'd2;
    localparam logic [CntW-1:0] RstPushDuration = 16'd500;
    localparam logic [CntW-1:0] RstStepsPerRev  = 16'd512;
    localparam logic            RstReverse      = 1'b1;
    localparam logic [CntW-1:0] RstHoldTime     = 16'd1000;
    localparam logic [AngW-1:0] RstRestAngle    = 8'd30;
    localparam logic [AngW-1:0] RstPushAngle    = 8'd110;

    typedef enum logic [2:0] {
        REG_STEP_INTERVAL = 3'd0,
        REG_PUSH_DURATION = 3'd1,
        REG_STEPS_PER_REV = 3'd2,
        REG_REVERSE       = 3'd3,
        REG_HOLD_TIME     = 3'd4,
        REG_REST_ANGLE    = 3'd5,
        REG_PUSH_ANGLE    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [CntW-1:0] step_interval;
        logic [CntW-1:0] push_duration;
        logic [CntW-1:0] steps_per_rev;
        logic            reverse;
        logic [CntW-1:0] hold_time;
        logic [AngW-1:0] rest_angle;
        logic [AngW-1:0] push_angle;
    } t_cfg;

    function automatic logic [CoilW-1:0] coil_of(input logic [PhaseW-1:0] ph);
        logic [CoilW-1:0] c;
        case (ph)
            3'd0:    c = 4'h1;
            3'd1:    c = 4'h3;
            3'd2:    c = 4'h2;
            3'd3:    c = 4'h6;
            3'd4:    c = 4'h4;
            3'd5:    c = 4'hC;
            3'd6:    c = 4'h8;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CntMax) ? v : v + 1'b1;
    endfunction

endpackage

// ----- rtl/core/shp_cfg.sv -----
module shp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shp_pkg::AddrW-1:0]   paddr,
    input  logic [shp_pkg::DataW-1:0]   pwdata,
    output logic [shp_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output shp_pkg::t_cfg               o_cfg
);
    import shp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_interval <= RstStepInterval;
            r_cfg.push_duration <= RstPushDuration;
            r_cfg.steps_per_rev <= RstStepsPerRev;
            r_cfg.reverse       <= RstReverse;
            r_cfg.hold_time     <= RstHoldTime;
            r_cfg.rest_angle    <= RstRestAngle;
            r_cfg.push_angle    <= RstPushAngle;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP_INTERVAL: r_cfg.step_interval <= pwdata[CntW-1:0];
                REG_PUSH_DURATION: r_cfg.push_duration <= pwdata[CntW-1:0];
                REG_STEPS_PER_REV: r_cfg.steps_per_rev <= pwdata[CntW-1:0];
                REG_REVERSE:       r_cfg.reverse       <= pwdata[0];
                REG_HOLD_TIME:     r_cfg.hold_time     <= pwdata[CntW-1:0];
                REG_REST_ANGLE:    r_cfg.rest_angle    <= pwdata[AngW-1:0];
                REG_PUSH_ANGLE:    r_cfg.push_angle    <= pwdata[AngW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (w_idx)
                REG_STEP_INTERVAL: prdata = DataW'(r_cfg.step_interval);
                REG_PUSH_DURATION: prdata = DataW'(r_cfg.push_duration);
                REG_STEPS_PER_REV: prdata = DataW'(r_cfg.steps_per_rev);
                REG_REVERSE:       prdata = DataW'(r_cfg.reverse);
                REG_HOLD_TIME:     prdata = DataW'(r_cfg.hold_time);
                REG_REST_ANGLE:    prdata = DataW'(r_cfg.rest_angle);
                REG_PUSH_ANGLE:    prdata = DataW'(r_cfg.push_angle);
                default:           prdata = '0;
            endcase
        end
    end

endmodule

// ----- rtl/core/shp_core.sv -----
module shp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  shp_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic                        i_advance,
    output logic                        o_take,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [shp_pkg::CoilW-1:0]   o_coil_pattern,
    output logic [shp_pkg::AngW-1:0]    o_servo_angle,
    output logic                        o_push_active,
    output logic                        o_step_taken
);
    import shp_pkg::*;

    logic [PhaseW-1:0] r_phase,    n_phase;
    logic [CntW-1:0]   r_step_el,  n_step_el;
    logic [CntW-1:0]   r_step_cnt, n_step_cnt;
    logic              r_pushing,  n_pushing;
    logic [CntW-1:0]   r_push_el,  n_push_el;
    logic [CntW-1:0]   r_hold,     n_hold;
    logic [CoilW-1:0]  r_coil,     n_coil;
    logic              n_stepped;
    logic              r_out_valid;
    logic [CoilW-1:0]  r_o_coil;
    logic [AngW-1:0]   r_o_angle;
    logic              r_o_push;
    logic              r_o_step;
    logic              w_fire;

    assign o_take = !r_out_valid || i_out_ready;
    assign w_fire = i_valid && o_take;

    always_comb begin
        n_phase    = r_phase;
        n_step_el  = r_step_el;
        n_step_cnt = r_step_cnt;
        n_pushing  = r_pushing;
        n_push_el  = r_push_el;
        n_hold     = r_hold;
        n_coil     = r_coil;
        n_stepped  = 1'b0;
        if (i_advance) begin
            n_step_el = sat_inc(r_step_el);
            if (r_hold != '0) begin
                n_hold = r_hold - 1'b1;
            end else begin
                if (r_pushing) begin
                    n_push_el = sat_inc(r_push_el);
                end
                if (n_step_el >= i_cfg.step_interval) begin
                    n_step_el  = '0;
                    n_stepped  = 1'b1;
                    n_phase    = i_cfg.reverse ? r_phase - 1'b1 : r_phase + 1'b1;
                    n_coil     = coil_of(n_phase);
                    n_step_cnt = sat_inc(r_step_cnt);
                    if (n_step_cnt >= i_cfg.steps_per_rev && !r_pushing) begin
                        n_step_cnt = '0;
                        n_pushing  = 1'b1;
                        n_push_el  = '0;
                    end
                end
                if (n_pushing && n_push_el >= i_cfg.push_duration) begin
                    n_pushing = 1'b0;
                    n_hold    = i_cfg.hold_time;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step_el   <= '0;
            r_step_cnt  <= '0;
            r_pushing   <= 1'b0;
            r_push_el   <= '0;
            r_hold      <= '0;
            r_coil      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase    <= n_phase;
                r_step_el  <= n_step_el;
                r_step_cnt <= n_step_cnt;
                r_pushing  <= n_pushing;
                r_push_el  <= n_push_el;
                r_hold     <= n_hold;
                r_coil     <= n_coil;
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_coil  <= n_coil;
            r_o_angle <= n_pushing ? i_cfg.push_angle : i_cfg.rest_angle;
            r_o_push  <= n_pushing;
            r_o_step  <= n_stepped;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coil_pattern = r_o_coil;
    assign o_servo_angle  = r_o_angle;
    assign o_push_active  = r_o_push;
    assign o_step_taken   = r_o_step;

endmodule

// ----- rtl/core/stepper_halfstep_with_push_timer.sv -----
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid/o_in_ready  | i_advance
// out     | output    | o_out_valid/i_out_ready| o_coil_pattern, o_servo_angle,
//         |           |                        | o_push_active, o_step_taken
// cfg     | input     | psel/penable/pready    | paddr, pwdata, prdata
//
// One item per clock sustained while i_out_ready holds; each item passes the input
// register, then the state update into the result register.
// Synchronous active-low reset clears all timers, phase and coils; config
// registers return to their defaults.
// A stalled result holds the core; the input register takes one more item.
module stepper_halfstep_with_push_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_advance,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [shp_pkg::CoilW-1:0]   o_coil_pattern,
    output logic [shp_pkg::AngW-1:0]    o_servo_angle,
    output logic                        o_push_active,
    output logic                        o_step_taken,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [shp_pkg::AddrW-1:0]   paddr,
    input  logic [shp_pkg::DataW-1:0]   pwdata,
    output logic [shp_pkg::DataW-1:0]   prdata,
    output logic                        pready
);
    import shp_pkg::*;

    t_cfg w_cfg;
    logic r_in_valid;
    logic r_in_adv;
    logic w_take;

    shp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_adv <= i_advance;
        end
    end

    shp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (r_in_valid),
        .i_advance      (r_in_adv),
        .o_take         (w_take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_coil_pattern (o_coil_pattern),
        .o_servo_angle  (o_servo_angle),
        .o_push_active  (o_push_active),
        .o_step_taken   (o_step_taken)
    );

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_take |=> r_in_valid && $stable(r_in_adv))
        else $error("input register lost an item");

    a_coil_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(o_coil_pattern) <= 2)
        else $error("bad coil pattern");

    a_step_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_step_taken |-> o_coil_pattern != '0)
        else $error("step with coils off");

    a_push_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_active |-> o_servo_angle == w_cfg.push_angle)
        else $error("push without push angle");

endmodule
